// File: hw/rtl/stc_pkg.sv
// stc_pkg: shared types and defaults for the source character tokenizer.
// Used by the result channel interface, the front, queue and back modules and the top level.
package stc_pkg;

  localparam int MAX_TOKEN_LEN_DEF = 256;
  localparam int QUEUE_DEPTH_DEF   = 4;

  typedef enum logic [3:0] {
    KIND_NUM   = 4'd0,
    KIND_NAME  = 4'd1,
    KIND_VAR   = 4'd2,
    KIND_STR   = 4'd3,
    KIND_OP    = 4'd4,
    KIND_SEMI  = 4'd5,
    KIND_EQ    = 4'd6,
    KIND_LP    = 4'd7,
    KIND_RP    = 4'd8,
    KIND_COMMA = 4'd9,
    KIND_EOF   = 4'd10,
    KIND_ERR   = 4'd11
  } kind_t;

  // One output beat.
  typedef struct packed {
    logic        is_text_char;
    kind_t       kind;
    logic [7:0]  char_out;
    logic [8:0]  token_length;
    logic [15:0] line_number;
    logic        last;
  } result_t;

  // Everything one input byte produces: one or two results.
  typedef struct packed {
    logic    two;
    result_t res0;
    result_t res1;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: hw/rtl/stc_if.sv
// Valid/ready channel interfaces for the tokenizer input and result streams.
// Depends on stc_pkg for the token kind type.
interface stc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_input;

  modport source (output valid, ch, end_of_input, input ready);
  modport sink   (input valid, ch, end_of_input, output ready);
endinterface

interface stc_out_if;
  logic           valid;
  logic           ready;
  logic           is_text_char;
  stc_pkg::kind_t kind;
  logic [7:0]     char_out;
  logic [8:0]     token_length;
  logic [15:0]    line_number;
  logic           last;

  modport source (output valid, is_text_char, kind, char_out, token_length, line_number,
                  last, input ready);
  modport sink   (input valid, is_text_char, kind, char_out, token_length, line_number,
                  last, output ready);
endinterface

// File: hw/rtl/stc_front.sv
// stc_front: accepts source bytes, runs the lexer state and builds result entries.
// Depends on stc_pkg and stc_in_if; pushes into stc_fifo.
module stc_front #(
  parameter int MAX_TOKEN_LEN = stc_pkg::MAX_TOKEN_LEN_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  stc_in_if.sink           in_chan,
  input  stc_pkg::q_stat_t q_stat,
  output logic             push,
  output stc_pkg::entry_t  push_entry
);
  import stc_pkg::*;

  localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LP    = 8'h28;
  localparam logic [7:0] CH_RP    = 8'h29;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_KW_V  = 8'h76;
  localparam logic [7:0] CH_KW_A  = 8'h61;
  localparam logic [7:0] CH_KW_R  = 8'h72;

  typedef enum logic [1:0] {MODE_IDLE, MODE_NUM, MODE_NAME, MODE_STR} mode_t;

  function automatic logic [7:0] kw_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = CH_KW_V;
      2'd1:    c = CH_KW_A;
      default: c = CH_KW_R;
    endcase
    return c;
  endfunction

  function automatic result_t make_res(input logic txt, input kind_t k, input logic [7:0] c,
                                       input logic [8:0] len, input logic [15:0] line);
    result_t r;
    r.is_text_char = txt;
    r.kind         = k;
    r.char_out     = c;
    r.token_length = len;
    r.line_number  = line;
    r.last         = 1'b0;
    return r;
  endfunction

  mode_t            mode_r, mode_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [1:0]       kwp_r, kwp_nxt;
  logic             kwf_r, kwf_nxt;
  logic [15:0]      line_r, line_nxt;
  logic             halted_r, halted_nxt;

  logic             go;
  logic             is_digit, is_letter, more, too_long, tk_ok;
  logic [LEN_W-1:0] len_inc;
  kind_t            fin_kind;
  result_t          fin_res;

  // start-of-token decode
  logic             st_has, st_lf, st_err;
  result_t          st_res;
  mode_t            st_mode;
  logic [LEN_W-1:0] st_len;
  logic [1:0]       st_kwp;
  logic             st_kwf;

  logic             has0, has1;
  result_t          r0, r1;

  assign in_chan.ready = !q_stat.full;
  assign go            = in_chan.valid && in_chan.ready;

  assign is_digit  = (in_chan.ch >= 8'h30) && (in_chan.ch <= 8'h39);
  assign is_letter = ((in_chan.ch >= 8'h41) && (in_chan.ch <= 8'h5A)) ||
                     ((in_chan.ch >= 8'h61) && (in_chan.ch <= 8'h7A));
  assign more      = (mode_r == MODE_NUM) ? is_digit : is_letter;
  assign too_long  = len_r >= LEN_W'(MAX_TOKEN_LEN);
  assign len_inc   = len_r + LEN_W'(1);
  assign tk_ok     = !kwf_r && (len_r < LEN_W'(3)) && (LEN_W'(kwp_r) == len_r) &&
                     (in_chan.ch == kw_char(len_r[1:0]));

  always_comb begin
    if (mode_r == MODE_NAME) begin
      fin_kind = (!kwf_r && kwp_r == 2'd3) ? KIND_VAR : KIND_NAME;
    end else if (mode_r == MODE_STR) begin
      fin_kind = KIND_STR;
    end else begin
      fin_kind = KIND_NUM;
    end
  end

  assign fin_res = make_res(1'b0, fin_kind, 8'h00, 9'(len_r), line_r);

  always_comb begin
    st_has  = 1'b0;
    st_lf   = 1'b0;
    st_err  = 1'b0;
    st_res  = make_res(1'b0, KIND_ERR, in_chan.ch, 9'd0, line_r);
    st_mode = MODE_IDLE;
    st_len  = '0;
    st_kwp  = 2'd0;
    st_kwf  = 1'b0;
    if (is_digit) begin
      st_has  = 1'b1;
      st_mode = MODE_NUM;
      st_len  = LEN_W'(1);
      st_res  = make_res(1'b1, KIND_NUM, in_chan.ch, 9'd1, line_r);
    end else if (is_letter) begin
      st_has  = 1'b1;
      st_mode = MODE_NAME;
      st_len  = LEN_W'(1);
      if (in_chan.ch == CH_KW_V) begin
        st_kwp = 2'd1;
      end else begin
        st_kwf = 1'b1;
      end
      st_res  = make_res(1'b1, KIND_NAME, in_chan.ch, 9'd1, line_r);
    end else begin
      unique case (in_chan.ch)
        CH_QUOTE: st_mode = MODE_STR;
        CH_SPACE, CH_CR: ;
        CH_LF: st_lf = 1'b1;
        CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: begin
          st_has = 1'b1;
          st_res = make_res(1'b0, KIND_OP, in_chan.ch, 9'd1, line_r);
        end
        CH_SEMI: begin
          st_has = 1'b1;
          st_res = make_res(1'b0, KIND_SEMI, in_chan.ch, 9'd1, line_r);
        end
        CH_EQ: begin
          st_has = 1'b1;
          st_res = make_res(1'b0, KIND_EQ, in_chan.ch, 9'd1, line_r);
        end
        CH_LP: begin
          st_has = 1'b1;
          st_res = make_res(1'b0, KIND_LP, in_chan.ch, 9'd1, line_r);
        end
        CH_RP: begin
          st_has = 1'b1;
          st_res = make_res(1'b0, KIND_RP, in_chan.ch, 9'd1, line_r);
        end
        CH_COMMA: begin
          st_has = 1'b1;
          st_res = make_res(1'b0, KIND_COMMA, in_chan.ch, 9'd1, line_r);
        end
        default: begin
          st_has = 1'b1;
          st_err = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    mode_nxt   = mode_r;
    len_nxt    = len_r;
    kwp_nxt    = kwp_r;
    kwf_nxt    = kwf_r;
    line_nxt   = line_r;
    halted_nxt = halted_r;
    has0       = 1'b0;
    has1       = 1'b0;
    r0         = fin_res;
    r1         = st_res;

    if (go && !halted_r) begin
      if (in_chan.end_of_input) begin
        if (mode_r == MODE_STR) begin
          has0       = 1'b1;
          r0         = make_res(1'b0, KIND_ERR, 8'h00, 9'd0, line_r);
          halted_nxt = 1'b1;
        end else begin
          has0 = 1'b1;
          if (mode_r != MODE_IDLE) begin
            has1 = 1'b1;
            r1   = make_res(1'b0, KIND_EOF, 8'h00, 9'd0, line_r);
          end else begin
            r0   = make_res(1'b0, KIND_EOF, 8'h00, 9'd0, line_r);
          end
          mode_nxt = MODE_IDLE;
          len_nxt  = '0;
          kwp_nxt  = 2'd0;
          kwf_nxt  = 1'b0;
        end
      end else begin
        unique case (mode_r)
          MODE_NUM, MODE_NAME: begin
            if (more) begin
              has0 = 1'b1;
              if (too_long) begin
                r0         = make_res(1'b0, KIND_ERR, in_chan.ch, 9'd0, line_r);
                halted_nxt = 1'b1;
              end else begin
                if (mode_r == MODE_NAME) begin
                  if (tk_ok) begin
                    kwp_nxt = kwp_r + 2'd1;
                  end else begin
                    kwf_nxt = 1'b1;
                  end
                end
                len_nxt = len_inc;
                r0      = make_res(1'b1, (mode_r == MODE_NUM) ? KIND_NUM : KIND_NAME,
                                   in_chan.ch, 9'(len_inc), line_r);
              end
            end else begin
              // token closed by this byte: record first, then the byte starts afresh
              has0       = 1'b1;
              has1       = st_has;
              mode_nxt   = st_mode;
              len_nxt    = st_len;
              kwp_nxt    = st_kwp;
              kwf_nxt    = st_kwf;
              halted_nxt = st_err;
              if (st_lf && line_r != 16'hFFFF) begin
                line_nxt = line_r + 16'd1;
              end
            end
          end
          MODE_STR: begin
            has0 = 1'b1;
            if (in_chan.ch == CH_QUOTE) begin
              mode_nxt = MODE_IDLE;
              len_nxt  = '0;
              kwp_nxt  = 2'd0;
              kwf_nxt  = 1'b0;
            end else if (too_long) begin
              r0         = make_res(1'b0, KIND_ERR, in_chan.ch, 9'd0, line_r);
              halted_nxt = 1'b1;
            end else begin
              len_nxt = len_inc;
              r0      = make_res(1'b1, KIND_STR, in_chan.ch, 9'(len_inc), line_r);
            end
          end
          default: begin
            has0       = st_has;
            r0         = st_res;
            mode_nxt   = st_mode;
            len_nxt    = st_len;
            kwp_nxt    = st_kwp;
            kwf_nxt    = st_kwf;
            halted_nxt = st_err;
            if (st_lf && line_r != 16'hFFFF) begin
              line_nxt = line_r + 16'd1;
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    push            = has0;
    push_entry.two  = has1;
    push_entry.res0 = r0;
    push_entry.res1 = r1;
    push_entry.res0.last = !has1;
    push_entry.res1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      len_r    <= '0;
      kwp_r    <= 2'd0;
      kwf_r    <= 1'b0;
      line_r   <= 16'd1;
      halted_r <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      len_r    <= len_nxt;
      kwp_r    <= kwp_nxt;
      kwf_r    <= kwf_nxt;
      line_r   <= line_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

// File: hw/rtl/stc_fifo.sv
// stc_fifo: short queue of result entries between front and back.
// Depends on stc_pkg.
module stc_fifo #(
  parameter int DEPTH = stc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  stc_pkg::entry_t  push_entry,
  input  logic             pop,
  output stc_pkg::entry_t  head,
  output stc_pkg::q_stat_t q_stat
);
  import stc_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.full  = cnt_r == CNT_W'(DEPTH);
  assign q_stat.empty = cnt_r == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

// File: hw/rtl/stc_back.sv
// stc_back: splits queued entries into single result beats and holds the output register.
// Depends on stc_pkg and stc_out_if; pops stc_fifo.
module stc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  stc_pkg::q_stat_t q_stat,
  input  stc_pkg::entry_t  head,
  output logic             pop,
  stc_out_if.source        out_chan
);
  import stc_pkg::*;

  logic    out_valid_r, out_valid_nxt;
  result_t out_data_r, out_data_nxt;
  logic    sel_r, sel_nxt;
  logic    load;

  assign load = (!out_valid_r || out_chan.ready) && !q_stat.empty;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    sel_nxt       = sel_r;
    pop           = 1'b0;
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = sel_r ? head.res1 : head.res0;
      if (!sel_r && head.two) begin
        sel_nxt = 1'b1;
      end else begin
        sel_nxt = 1'b0;
        pop     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sel_r       <= sel_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.is_text_char = out_data_r.is_text_char;
  assign out_chan.kind         = out_data_r.kind;
  assign out_chan.char_out     = out_data_r.char_out;
  assign out_chan.token_length = out_data_r.token_length;
  assign out_chan.line_number  = out_data_r.line_number;
  assign out_chan.last         = out_data_r.last;

endmodule

// File: hw/rtl/source_char_tokenizer.sv
// source_char_tokenizer: streaming lexer top level.
// Depends on stc_pkg, stc_if, stc_front, stc_fifo and stc_back.
//
// Takes one source byte per beat and emits token beats: every character of a
// number, name or string as it arrives, then a record with the token kind and
// length; single-character punctuation gives one record; end of input gives an
// eof record after any pending token. A byte that both closes a token and
// starts another (or an end of input after a pending token) yields two result
// beats, which the back end sends one after the other. The front and back are
// parted by a QUEUE_DEPTH-entry queue, so input runs at one byte per cycle
// until the queue fills; in_chan.ready drops only while it is full. An input
// beat's first result is registered in the queue and then in the output
// register. An error record (bad byte, token over MAX_TOKEN_LEN, or end of
// input inside a string) halts the block: later bytes are still taken but give
// no results until reset.
module source_char_tokenizer #(
  parameter int MAX_TOKEN_LEN = stc_pkg::MAX_TOKEN_LEN_DEF,
  parameter int QUEUE_DEPTH   = stc_pkg::QUEUE_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  stc_in_if.sink    in_chan,
  stc_out_if.source out_chan
);
  import stc_pkg::*;

  // front -> queue
  logic    push;
  entry_t  push_entry;
  // queue -> back
  logic    pop;
  entry_t  head;
  q_stat_t q_stat;

  stc_front #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .q_stat    (q_stat),
    .push      (push),
    .push_entry(push_entry)
  );

  stc_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  stc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_stat  (q_stat),
    .head    (head),
    .pop     (pop),
    .out_chan(out_chan)
  );

`ifndef NO_ASSERTIONS
  // Once the error beat leaves, the block stays silent until reset.
  a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.ready && out_chan.kind == KIND_ERR) |=> !out_chan.valid)
    else $error("result beat after error");

  // Error is always the closing beat of its byte.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.kind == KIND_ERR) |-> out_chan.last)
    else $error("error beat without last");

  // Text beats belong to a number, name or string and carry a running length.
  a_text_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.is_text_char) |->
      ((out_chan.kind == KIND_NUM || out_chan.kind == KIND_NAME ||
        out_chan.kind == KIND_STR) && out_chan.token_length != 9'd0))
    else $error("bad text beat");

  // Backpressure on input only while results are waiting at the output.
  a_stall_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> out_chan.valid)
    else $error("input stalled with no output pending");
`endif

endmodule
